FILE: rtl/pos_pkg.sv
// Shared types, field widths and codes for the palette order swap search block.
package pos_pkg;

  // Field widths of the request and response channels
  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 32;
  localparam int LEN_W   = 9;
  localparam int PLEN_W  = 26;

  // Color channel layout and distance widths
  localparam int CH_W   = 8;
  localparam int DIST_W = 18;  // sum of up to four squared 8-bit differences
  localparam int SUM_W  = 20;  // sum of up to four distances

  // Longest palette walk the indices can address
  localparam int MAX_LEN = 256;

  // Defaults for the top-level parameters
  localparam int PALETTE_SIZE_DEF = 256;
  localparam int CHANNELS_DEF     = 4;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_LEN = '0;
  localparam logic [LEN_W-1:0]  LEN_RESET = 9'd256;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD,
    FUNC_SWAP,
    FUNC_MEASURE,
    FUNC_TRY,
    FUNC_READ
  } func_e;

endpackage

FILE: rtl/pos_if.sv
// Request and response channel interfaces of the palette order swap search block.
interface pos_req_if import pos_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [IDX_W-1:0]   index_a;
  logic [IDX_W-1:0]   index_b;
  logic [COLOR_W-1:0] color;

  modport source (output valid, func, index_a, index_b, color, input ready);
  modport sink   (input valid, func, index_a, index_b, color, output ready);
endinterface

interface pos_rsp_if import pos_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] read_color;
  logic               swapped;
  logic [PLEN_W-1:0]  path_length;
  logic               status;

  modport source (output valid, read_color, swapped, path_length, status, input ready);
  modport sink   (input valid, read_color, swapped, path_length, status, output ready);
endinterface

FILE: rtl/pos_ram.sv
// Generic single-port RAM with registered read data.
module pos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pos_dist.sv
// Squared color distance over the low channels of two packed colors.
module pos_dist import pos_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic [COLOR_W-1:0] x_i,
  input  logic [COLOR_W-1:0] y_i,
  output logic [DIST_W-1:0]  dist_o
);

  always_comb begin : dist_calc
    logic [CH_W-1:0]   p;
    logic [CH_W-1:0]   q;
    logic [CH_W-1:0]   d;
    logic [2*CH_W-1:0] sq;
    logic [DIST_W-1:0] sum;
    sum = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      p   = x_i[k*CH_W +: CH_W];
      q   = y_i[k*CH_W +: CH_W];
      d   = (p > q) ? (p - q) : (q - p);
      sq  = d * d;
      sum = sum + DIST_W'(sq);
    end
    dist_o = sum;
  end

endmodule

FILE: rtl/palette_order_swap_search_core.sv
// Top level: palette store, request sequencer and running path length.
//
// The palette lives in one single-port RAM with a registered read, so every
// request is worked through at most one memory access per cycle, and the
// block takes one request at a time. A load writes its entry; a read fetches
// one entry; a plain swap reads a and b and writes both back; a try swap
// reads a-1, a, a+1, b-1, b, b+1, then forms the eight distances (four when
// a and b are neighbours) two at a time in the two distance units, makes one
// compare and, when the swap is taken, two write-backs; a measure reads each
// entry of the effective length in turn and sums the distance of each
// neighbour pair as its data returns. A request with an index out of range
// goes straight to its result with status set. The next request is taken the
// cycle after the result enters the output register; a result waiting there
// does not block work on the next request, only its delivery. Palette entries
// have no reset; running length resets to zero and palette_length to 256.
// palette_length sits at byte address 0 of the configuration port and must
// only be written while the block is idle.
module palette_order_swap_search_core import pos_pkg::*; #(
  parameter int PALETTE_SIZE = PALETTE_SIZE_DEF,
  parameter int CHANNELS     = CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pos_req_if.sink           req_i,
  pos_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW     = $clog2(PALETTE_SIZE);
  localparam int LenCap = (PALETTE_SIZE < MAX_LEN) ? PALETTE_SIZE : MAX_LEN;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_RD, ST_CALC, ST_DEC, ST_WRA, ST_WRB, ST_MEAS, ST_DONE
  } state_e;

  // Neighbourhood shape of a try swap
  typedef enum logic [1:0] {MODE_FAR, MODE_AB, MODE_BA} mode_e;

  // Holding registers for the entries around a and b
  typedef enum logic [2:0] {
    SLOT_AM1, SLOT_A, SLOT_AP1, SLOT_BM1, SLOT_B, SLOT_BP1
  } slot_e;

  // Map the n-th read of a request onto the entry it fetches
  function automatic slot_e slot_of(func_e op, logic [2:0] c);
    slot_e s;
    case (op)
      FUNC_TRY:  s = slot_e'(c);
      FUNC_SWAP: s = (c == 3'd0) ? SLOT_A : SLOT_B;
      default:   s = SLOT_A;
    endcase
    return s;
  endfunction

  function automatic logic [AW-1:0] slot_addr(slot_e s, logic [IDX_W-1:0] a,
                                              logic [IDX_W-1:0] b);
    logic [IDX_W:0] ax;
    logic [IDX_W:0] bx;
    logic [IDX_W:0] r;
    ax = {1'b0, a};
    bx = {1'b0, b};
    case (s)
      SLOT_AM1: r = ax - (IDX_W+1)'(1);
      SLOT_A:   r = ax;
      SLOT_AP1: r = ax + (IDX_W+1)'(1);
      SLOT_BM1: r = bx - (IDX_W+1)'(1);
      SLOT_B:   r = bx;
      SLOT_BP1: r = bx + (IDX_W+1)'(1);
      default:  r = ax;
    endcase
    return AW'(r);
  endfunction

  // Control and datapath registers
  state_e             state_q, state_d;
  func_e              op_q, op_d;
  mode_e              mode_q, mode_d;
  logic [IDX_W-1:0]   a_q, a_d, b_q, b_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [1:0]         step_q, step_d;
  logic [LEN_W-1:0]   mi_q, mi_d;
  logic               rv_q, rv_d, first_q, first_d;
  logic [PLEN_W-1:0]  acc_q, acc_d;
  logic [COLOR_W-1:0] prev_q, prev_d;
  logic [COLOR_W-1:0] e_am1_q, e_am1_d, e_a_q, e_a_d, e_ap1_q, e_ap1_d;
  logic [COLOR_W-1:0] e_bm1_q, e_bm1_d, e_b_q, e_b_d, e_bp1_q, e_bp1_d;
  logic [SUM_W-1:0]   as_q, as_d, sw_q, sw_d;
  logic [PLEN_W-1:0]  run_q, run_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               took_q, took_d, status_q, status_d;
  logic               out_v_q, out_v_d;
  logic [COLOR_W-1:0] out_color_q, out_color_d;
  logic               out_swapped_q, out_swapped_d;
  logic [PLEN_W-1:0]  out_plen_q, out_plen_d;
  logic               out_status_q, out_status_d;

  // Memory port
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [COLOR_W-1:0] ram_wdata;
  logic [COLOR_W-1:0] ram_rdata;

  // Distance units: unit 0 serves the present order and the measure walk,
  // unit 1 the swapped order
  logic [COLOR_W-1:0] x0, y0, x1, y1;
  logic [DIST_W-1:0]  d0, d1;

  logic [LEN_W-1:0]   n_eff;
  logic               accept, cfg_we;
  logic               a_ok, b_ok, a_in, b_in;
  logic [2:0]         rd_total;
  logic               take;

  pos_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  pos_dist #(.CHANNELS(CHANNELS)) u_dist_cur (.x_i(x0), .y_i(y0), .dist_o(d0));
  pos_dist #(.CHANNELS(CHANNELS)) u_dist_swp (.x_i(x1), .y_i(y1), .dist_o(d1));

  // Configuration port: one register, no wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_LEN);
  assign prdata = (paddr[APB_AW-1:2] == REG_LEN) ? APB_DW'(len_q) : '0;

  // Limit the configured length to what the store and the indices can hold
  assign n_eff = (len_q > LEN_W'(LenCap)) ? LEN_W'(LenCap) : len_q;

  // Index checks on the incoming request
  assign a_in   = ({1'b0, req_i.index_a} < n_eff);
  assign b_in   = ({1'b0, req_i.index_b} < n_eff);
  assign a_ok   = (req_i.index_a != '0) && (({1'b0, req_i.index_a} + 9'd1) < n_eff);
  assign b_ok   = (req_i.index_b != '0) && (({1'b0, req_i.index_b} + 9'd1) < n_eff);

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && (state_q == ST_IDLE);

  assign rsp_o.valid       = out_v_q;
  assign rsp_o.read_color  = out_color_q;
  assign rsp_o.swapped     = out_swapped_q;
  assign rsp_o.path_length = out_plen_q;
  assign rsp_o.status      = out_status_q;

  always_comb begin
    case (op_q)
      FUNC_TRY:  rd_total = 3'd6;
      FUNC_SWAP: rd_total = 3'd2;
      default:   rd_total = 3'd1;
    endcase
  end

  assign take = (sw_q < as_q);

  // Operand selection for the distance units
  always_comb begin
    x0 = e_a_q;
    y0 = e_ap1_q;
    x1 = e_b_q;
    y1 = e_ap1_q;
    if (state_q == ST_MEAS) begin
      x0 = prev_q;
      y0 = ram_rdata;
    end else begin
      case (mode_q)
        MODE_AB: begin
          // b follows a: only the outer neighbours change partners
          if (step_q[0]) begin
            x0 = e_b_q;   y0 = e_bp1_q;  x1 = e_a_q;   y1 = e_bp1_q;
          end else begin
            x0 = e_am1_q; y0 = e_a_q;    x1 = e_am1_q; y1 = e_b_q;
          end
        end
        MODE_BA: begin
          if (step_q[0]) begin
            x0 = e_a_q;   y0 = e_ap1_q;  x1 = e_b_q;   y1 = e_ap1_q;
          end else begin
            x0 = e_bm1_q; y0 = e_b_q;    x1 = e_bm1_q; y1 = e_a_q;
          end
        end
        default: begin
          case (step_q)
            2'd0: begin x0 = e_a_q; y0 = e_ap1_q; x1 = e_b_q; y1 = e_ap1_q; end
            2'd1: begin x0 = e_a_q; y0 = e_am1_q; x1 = e_b_q; y1 = e_am1_q; end
            2'd2: begin x0 = e_b_q; y0 = e_bp1_q; x1 = e_a_q; y1 = e_bp1_q; end
            default: begin x0 = e_b_q; y0 = e_bm1_q; x1 = e_a_q; y1 = e_bm1_q; end
          endcase
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    slot_e cap;
    logic  issue;
    state_d       = state_q;
    op_d          = op_q;
    mode_d        = mode_q;
    a_d           = a_q;
    b_d           = b_q;
    color_d       = color_q;
    cnt_d         = cnt_q;
    step_d        = step_q;
    mi_d          = mi_q;
    rv_d          = rv_q;
    first_d       = first_q;
    acc_d         = acc_q;
    prev_d        = prev_q;
    e_am1_d       = e_am1_q;
    e_a_d         = e_a_q;
    e_ap1_d       = e_ap1_q;
    e_bm1_d       = e_bm1_q;
    e_b_d         = e_b_q;
    e_bp1_d       = e_bp1_q;
    as_d          = as_q;
    sw_d          = sw_q;
    run_d         = run_q;
    len_d         = cfg_we ? pwdata[LEN_W-1:0] : len_q;
    took_d        = took_q;
    status_d      = status_q;
    out_color_d   = out_color_q;
    out_swapped_d = out_swapped_q;
    out_plen_d    = out_plen_q;
    out_status_d  = out_status_q;
    // Drop the held result once it is taken
    out_v_d       = out_v_q && !rsp_o.ready;
    ram_we        = 1'b0;
    ram_addr      = AW'(a_q);
    ram_wdata     = color_q;
    cap           = slot_of(op_q, cnt_q - 3'd1);
    issue         = (mi_q < n_eff);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = func_e'(req_i.func);
          a_d      = req_i.index_a;
          b_d      = req_i.index_b;
          color_d  = req_i.color;
          status_d = 1'b0;
          took_d   = 1'b0;
          cnt_d    = '0;
          step_d   = '0;
          as_d     = '0;
          sw_d     = '0;
          if ({1'b0, req_i.index_b} == {1'b0, req_i.index_a} + 9'd1) begin
            mode_d = MODE_AB;
          end else if ({1'b0, req_i.index_a} == {1'b0, req_i.index_b} + 9'd1) begin
            mode_d = MODE_BA;
          end else begin
            mode_d = MODE_FAR;
          end
          state_d = ST_DONE;
          case (func_e'(req_i.func))
            FUNC_LOAD: begin
              if (a_in) state_d = ST_LOAD; else status_d = 1'b1;
            end
            FUNC_SWAP: begin
              if (a_in && b_in) state_d = ST_RD; else status_d = 1'b1;
            end
            FUNC_MEASURE: begin
              state_d = ST_MEAS;
              mi_d    = '0;
              rv_d    = 1'b0;
              first_d = 1'b1;
              acc_d   = '0;
            end
            FUNC_TRY: begin
              if (a_ok && b_ok) state_d = ST_RD; else status_d = 1'b1;
            end
            FUNC_READ: begin
              if (a_in) state_d = ST_RD; else status_d = 1'b1;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_LOAD: begin
        ram_we    = 1'b1;
        ram_addr  = AW'(a_q);
        ram_wdata = color_q;
        state_d   = ST_DONE;
      end

      ST_RD: begin
        // Issue one read a cycle, capture the previous one
        if (cnt_q < rd_total) begin
          ram_addr = slot_addr(slot_of(op_q, cnt_q), a_q, b_q);
        end
        if (cnt_q != 3'd0) begin
          case (cap)
            SLOT_AM1: e_am1_d = ram_rdata;
            SLOT_A:   e_a_d   = ram_rdata;
            SLOT_AP1: e_ap1_d = ram_rdata;
            SLOT_BM1: e_bm1_d = ram_rdata;
            SLOT_B:   e_b_d   = ram_rdata;
            SLOT_BP1: e_bp1_d = ram_rdata;
            default:  e_a_d   = ram_rdata;
          endcase
        end
        if (cnt_q == rd_total) begin
          case (op_q)
            FUNC_TRY:  state_d = ST_CALC;
            FUNC_SWAP: state_d = ST_WRA;
            default:   state_d = ST_DONE;
          endcase
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end

      ST_CALC: begin
        if ((mode_q == MODE_FAR) || !step_q[1]) begin
          as_d = as_q + SUM_W'(d0);
          sw_d = sw_q + SUM_W'(d1);
        end
        if (step_q == 2'd3) begin
          state_d = ST_DEC;
        end else begin
          step_d = step_q + 2'd1;
        end
      end

      ST_DEC: begin
        if (take) begin
          run_d   = run_q - PLEN_W'(as_q - sw_q);
          took_d  = 1'b1;
          state_d = ST_WRA;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_WRA: begin
        ram_we    = 1'b1;
        ram_addr  = AW'(a_q);
        ram_wdata = e_b_q;
        state_d   = ST_WRB;
      end

      ST_WRB: begin
        ram_we    = 1'b1;
        ram_addr  = AW'(b_q);
        ram_wdata = e_a_q;
        state_d   = ST_DONE;
      end

      ST_MEAS: begin
        if (issue) begin
          ram_addr = AW'(mi_q);
          mi_d     = mi_q + 9'd1;
        end
        rv_d = issue;
        if (rv_q) begin
          if (!first_q) begin
            acc_d = acc_q + PLEN_W'(d0);
          end
          prev_d  = ram_rdata;
          first_d = 1'b0;
        end
        if (!issue && !rv_q) begin
          run_d   = acc_q;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hold until the output register is free
        if (!out_v_q || rsp_o.ready) begin
          out_v_d       = 1'b1;
          out_color_d   = ((op_q == FUNC_READ) && !status_q) ? e_a_q : '0;
          out_swapped_d = took_q;
          out_plen_d    = run_q;
          out_status_d  = status_q;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= FUNC_LOAD;
      mode_q        <= MODE_FAR;
      a_q           <= '0;
      b_q           <= '0;
      color_q       <= '0;
      cnt_q         <= '0;
      step_q        <= '0;
      mi_q          <= '0;
      rv_q          <= 1'b0;
      first_q       <= 1'b1;
      acc_q         <= '0;
      prev_q        <= '0;
      e_am1_q       <= '0;
      e_a_q         <= '0;
      e_ap1_q       <= '0;
      e_bm1_q       <= '0;
      e_b_q         <= '0;
      e_bp1_q       <= '0;
      as_q          <= '0;
      sw_q          <= '0;
      run_q         <= '0;
      len_q         <= LEN_RESET;
      took_q        <= 1'b0;
      status_q      <= 1'b0;
      out_v_q       <= 1'b0;
      out_color_q   <= '0;
      out_swapped_q <= 1'b0;
      out_plen_q    <= '0;
      out_status_q  <= 1'b0;
    end else begin
      state_q       <= state_d;
      op_q          <= op_d;
      mode_q        <= mode_d;
      a_q           <= a_d;
      b_q           <= b_d;
      color_q       <= color_d;
      cnt_q         <= cnt_d;
      step_q        <= step_d;
      mi_q          <= mi_d;
      rv_q          <= rv_d;
      first_q       <= first_d;
      acc_q         <= acc_d;
      prev_q        <= prev_d;
      e_am1_q       <= e_am1_d;
      e_a_q         <= e_a_d;
      e_ap1_q       <= e_ap1_d;
      e_bm1_q       <= e_bm1_d;
      e_b_q         <= e_b_d;
      e_bp1_q       <= e_bp1_d;
      as_q          <= as_d;
      sw_q          <= sw_d;
      run_q         <= run_d;
      len_q         <= len_d;
      took_q        <= took_d;
      status_q      <= status_d;
      out_v_q       <= out_v_d;
      out_color_q   <= out_color_d;
      out_swapped_q <= out_swapped_d;
      out_plen_q    <= out_plen_d;
      out_status_q  <= out_status_d;
    end
  end

  // A rejected request never reports a swap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.status && rsp_o.swapped))
    else $error("response carries both error status and swap");

  // A taken swap always moves the running length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEC) && take |=> (run_q != $past(run_q)))
    else $error("swap taken without a length update");

  // The measure walk never runs past the longest palette
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MEAS) |-> (mi_q <= LEN_W'(MAX_LEN)))
    else $error("measure walk index out of range");

endmodule
